/* rtl/core/first_fit_unit_allocator_defines.svh */
// assertion macros used by the port-level checker
`ifndef FIRST_FIT_UNIT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FFUA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FFUA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ffua_pkg.sv */
// shared types, constants and helpers of the first-fit allocator
`timescale 1ns / 1ps
`default_nettype none
package ffua_pkg;

    localparam int PAGE_UNITS    = 4096;
    localparam int SIZE_W        = 13;
    localparam int UNITS_PER_ROW = (PAGE_UNITS >= 8) ? 8 : ((PAGE_UNITS >= 4) ? 4 : 2);
    localparam int LANE_W        = $clog2(UNITS_PER_ROW);
    localparam int ROW_COUNT     = (PAGE_UNITS + UNITS_PER_ROW - 1) / UNITS_PER_ROW;
    localparam int ROW_W         = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int UNIT_W        = ROW_W + LANE_W;
    localparam int RUN_W         = $clog2(PAGE_UNITS + 1);
    localparam int SUM_W         = ((UNIT_W > SIZE_W) ? UNIT_W : SIZE_W) + 2;

    localparam logic MODE_ALLOC      = 1'b0;
    localparam logic MODE_FREE       = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;
    localparam logic REG_REGION_BASE = 1'b0;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] request_size;
        logic [31:0]       free_address;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [31:0] granted_address;
    } out_item_t;

    typedef struct packed {
        logic [UNITS_PER_ROW-1:0]             used;
        logic [UNITS_PER_ROW-1:0][SIZE_W-1:0] len;
    } row_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        row_t             wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] lo;
        logic [UNIT_W-1:0] hi;
        logic              alloc;
        logic [SIZE_W-1:0] size;
    } upd_cmd_t;

    function automatic row_t reset_row();
        row_t r;
        r.used = '0;
        for (int j = 0; j < UNITS_PER_ROW; j++) begin
            r.len[j] = SIZE_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ffua_row_ram.sv */
// row memory holding used flags and run lengths, registered read
`timescale 1ns / 1ps
`default_nettype none
module ffua_row_ram (
    input  wire logic              aclk,
    input  wire ffua_pkg::mem_req_t req,
    output ffua_pkg::row_t         rd_data
);

    ffua_pkg::row_t mem [ffua_pkg::ROW_COUNT];
    ffua_pkg::row_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/core/ffua_row_update.sv */
// per-lane modify of one row: mark a run used or return it to free
`timescale 1ns / 1ps
`default_nettype none
module ffua_row_update (
    input  wire ffua_pkg::row_t            old_row,
    input  wire logic [ffua_pkg::ROW_W-1:0] row_idx,
    input  wire ffua_pkg::upd_cmd_t        cmd,
    output ffua_pkg::row_t                 new_row
);

    always_comb begin
        logic [ffua_pkg::UNIT_W-1:0] unit;
        new_row = old_row;
        for (int j = 0; j < ffua_pkg::UNITS_PER_ROW; j++) begin
            unit = {row_idx, ffua_pkg::LANE_W'(j)};
            if (unit >= cmd.lo && unit <= cmd.hi) begin
                new_row.used[j] = cmd.alloc;
                // on allocation the run start takes the size, every other unit goes back to one
                if (cmd.alloc && unit == cmd.lo) begin
                    new_row.len[j] = cmd.size;
                end else begin
                    new_row.len[j] = ffua_pkg::SIZE_W'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ffua_seq.sv */
// sequencer: clearing sweep, first-fit scan, lookup and read-modify-write of rows
`timescale 1ns / 1ps
`default_nettype none
module ffua_seq (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire ffua_pkg::in_item_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output ffua_pkg::out_item_t             m_data,
    input  wire logic [31:0]                region_base,
    output ffua_pkg::mem_req_t              mem_req,
    input  wire ffua_pkg::row_t             rd_data,
    output ffua_pkg::upd_cmd_t              upd_cmd,
    output logic [ffua_pkg::ROW_W-1:0]      upd_row_idx,
    input  wire ffua_pkg::row_t             upd_row
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_LOOK, ST_RMW, ST_DONE
    } state_t;

    localparam logic [ffua_pkg::ROW_W-1:0] LAST_ROW = ffua_pkg::ROW_W'(ffua_pkg::ROW_COUNT - 1);

    state_t                        state_reg,  state_next;
    logic [ffua_pkg::ROW_W-1:0]    row_reg,    row_next;
    logic [ffua_pkg::RUN_W-1:0]    run_reg,    run_next;
    ffua_pkg::upd_cmd_t            cmd_reg,    cmd_next;
    logic                          grant_reg,  grant_next;
    logic                          status_reg, status_next;
    logic                          m_valid_reg, m_valid_next;
    ffua_pkg::out_item_t           m_data_reg, m_data_next;

    // scan of the row arriving from memory
    logic [ffua_pkg::RUN_W-1:0]    run_v;
    logic                          hit;
    logic [ffua_pkg::UNIT_W-1:0]   end_unit;
    logic [ffua_pkg::UNIT_W-1:0]   start_unit;

    always_comb begin
        logic [ffua_pkg::UNIT_W-1:0] unit;
        logic                        used;
        run_v    = run_reg;
        hit      = 1'b0;
        end_unit = '0;
        for (int j = 0; j < ffua_pkg::UNITS_PER_ROW; j++) begin
            unit = {row_reg, ffua_pkg::LANE_W'(j)};
            used = rd_data.used[j] ||
                   (ffua_pkg::SUM_W'(unit) >= ffua_pkg::SUM_W'(ffua_pkg::PAGE_UNITS));
            if (used) begin
                run_v = '0;
            end else begin
                run_v = run_v + ffua_pkg::RUN_W'(1);
            end
            if (!hit && ffua_pkg::SUM_W'(run_v) >= ffua_pkg::SUM_W'(cmd_reg.size)) begin
                hit      = 1'b1;
                end_unit = unit;
            end
        end
        start_unit = ffua_pkg::UNIT_W'(ffua_pkg::SUM_W'(end_unit) + ffua_pkg::SUM_W'(1)
                                       - ffua_pkg::SUM_W'(cmd_reg.size));
    end

    // free: offset into the page and end of the stored run
    logic [31:0]                   free_ofs;
    logic [ffua_pkg::SIZE_W-1:0]   stored_len;
    logic [ffua_pkg::SUM_W-1:0]    free_end;

    assign free_ofs   = s_data.free_address - region_base;
    assign stored_len = rd_data.len[cmd_reg.lo[ffua_pkg::LANE_W-1:0]];
    assign free_end   = ffua_pkg::SUM_W'(cmd_reg.lo) + ffua_pkg::SUM_W'(stored_len)
                        - ffua_pkg::SUM_W'(1);

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        run_next     = run_reg;
        cmd_next     = cmd_reg;
        grant_next   = grant_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_req      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_reg;
                mem_req.wr_data = ffua_pkg::reset_row();
                if (row_reg == LAST_ROW) begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    row_next = row_reg + ffua_pkg::ROW_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next.size  = s_data.request_size;
                    cmd_next.alloc = (s_data.mode == ffua_pkg::MODE_ALLOC);
                    grant_next     = 1'b0;
                    status_next    = ffua_pkg::STATUS_OK;
                    if (s_data.mode == ffua_pkg::MODE_ALLOC) begin
                        if (s_data.request_size == '0 ||
                            32'(s_data.request_size) > 32'(ffua_pkg::PAGE_UNITS)) begin
                            status_next = ffua_pkg::STATUS_NO_SPACE;
                            state_next  = ST_DONE;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            row_next        = '0;
                            run_next        = '0;
                            state_next      = ST_SCAN;
                        end
                    end else if (free_ofs < 32'(ffua_pkg::PAGE_UNITS)) begin
                        cmd_next.lo     = ffua_pkg::UNIT_W'(free_ofs);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = free_ofs[ffua_pkg::UNIT_W-1:ffua_pkg::LANE_W];
                        row_next        = free_ofs[ffua_pkg::UNIT_W-1:ffua_pkg::LANE_W];
                        state_next      = ST_LOOK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                run_next = run_v;
                if (hit) begin
                    cmd_next.lo     = start_unit;
                    cmd_next.hi     = end_unit;
                    grant_next      = 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = start_unit[ffua_pkg::UNIT_W-1:ffua_pkg::LANE_W];
                    row_next        = start_unit[ffua_pkg::UNIT_W-1:ffua_pkg::LANE_W];
                    state_next      = ST_RMW;
                end else if (row_reg == LAST_ROW) begin
                    status_next = ffua_pkg::STATUS_NO_SPACE;
                    state_next  = ST_DONE;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = row_reg + ffua_pkg::ROW_W'(1);
                    row_next        = row_reg + ffua_pkg::ROW_W'(1);
                end
            end
            ST_LOOK: begin
                // clearing stops at the last unit of the page
                if (free_end >= ffua_pkg::SUM_W'(ffua_pkg::PAGE_UNITS)) begin
                    cmd_next.hi = ffua_pkg::UNIT_W'(ffua_pkg::PAGE_UNITS - 1);
                end else begin
                    cmd_next.hi = ffua_pkg::UNIT_W'(free_end);
                end
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_reg;
                state_next      = ST_RMW;
            end
            ST_RMW: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_reg;
                mem_req.wr_data = upd_row;
                if (row_reg == cmd_reg.hi[ffua_pkg::UNIT_W-1:ffua_pkg::LANE_W]) begin
                    state_next = ST_DONE;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = row_reg + ffua_pkg::ROW_W'(1);
                    row_next        = row_reg + ffua_pkg::ROW_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_data_next.status = status_reg;
                    m_data_next.granted_address =
                        grant_reg ? (region_base + 32'(cmd_reg.lo)) : '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
        run_reg    <= run_next;
        cmd_reg    <= cmd_next;
        grant_reg  <= grant_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign upd_cmd     = cmd_reg;
    assign upd_row_idx = row_reg;

endmodule
`default_nettype wire

/* rtl/core/first_fit_unit_allocator.sv */
// top level of the first-fit unit allocator with its register port
// allocate: a scan row a cycle then a rmw row a cycle; no fit: every row is scanned first
// free: a lookup, then a rmw row a cycle; rejected size or out-of-page: straight to the result
// throughput: one transaction at a time, set by the single row memory port pair
// reset: synchronous active low; a clearing sweep over all ROW_COUNT rows (512) follows,
//   with s_ready low until it ends; register writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none
module first_fit_unit_allocator (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ffua_pkg::in_item_t  s_data,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ffua_pkg::out_item_t      m_data,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // register index sits above the byte offset bits
    logic        reg_index;
    logic [31:0] region_base_reg, region_base_next;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_comb begin
        region_base_next = region_base_reg;
        if (psel && penable && pwrite && reg_index == ffua_pkg::REG_REGION_BASE) begin
            region_base_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg <= '0;
        end else begin
            region_base_reg <= region_base_next;
        end
    end

    // reads beyond the register list return zero
    assign prdata = (reg_index == ffua_pkg::REG_REGION_BASE) ? region_base_reg : '0;

    // row memory and its modify path
    ffua_pkg::mem_req_t          mem_req;
    ffua_pkg::row_t              rd_data;
    ffua_pkg::row_t              upd_row;
    ffua_pkg::upd_cmd_t          upd_cmd;
    logic [ffua_pkg::ROW_W-1:0]  upd_row_idx;

    ffua_row_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // modified row goes back on the write port in the cycle after its read
    ffua_row_update u_update (
        .old_row (rd_data),
        .row_idx (upd_row_idx),
        .cmd     (upd_cmd),
        .new_row (upd_row)
    );

    // clearing sweep, scan, lookup, update sequencing and the result register
    ffua_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .region_base (region_base_reg),
        .mem_req     (mem_req),
        .rd_data     (rd_data),
        .upd_cmd     (upd_cmd),
        .upd_row_idx (upd_row_idx),
        .upd_row     (upd_row)
    );

endmodule
`default_nettype wire

/* rtl/core/ffua_checker.sv */
// port-level checks of the allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_unit_allocator_defines.svh"
module ffua_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire ffua_pkg::out_item_t m_data
);

    `FFUA_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")
    `FFUA_ASSERT_NOW(a_fail_no_addr, aclk, aresetn, m_valid && m_data.status == ffua_pkg::STATUS_NO_SPACE, m_data.granted_address == '0, "failed allocation carries an address")
    `FFUA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken while another is in progress")

endmodule

bind first_fit_unit_allocator ffua_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
